@@ sv/tidba_pkg.sv @@
`timescale 1ns / 1ps
// Package for the task id to buffer address locator.
// Holds sizes, request and status codes, and the divider result type; no dependencies.
package tidba_pkg;

	localparam int MAX_BUFFERS = 16;
	localparam int IDX_W = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
	localparam int CNT_W = $clog2(MAX_BUFFERS + 1);
	localparam int LIMIT_W = 5;
	localparam int CAP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	localparam int ID_W = 32;
	localparam int ADDR_W = 32;
	localparam int SIZE_W = 16;
	localparam int DIV_W = 32;
	localparam int DSR_W = 16;
	localparam int DCNT_W = $clog2(DIV_W + 1);

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);
	localparam logic [SIZE_W-1:0] BSIZE_RESET = SIZE_W'(4096);
	localparam logic [SIZE_W-1:0] TSIZE_RESET = SIZE_W'(64);

	typedef enum logic [1:0] {
		ACT_RESET = 2'd0,
		ACT_ADD = 2'd1,
		ACT_LOOKUP = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK = 2'd0,
		STAT_FULL = 2'd1,
		STAT_MISS = 2'd2,
		STAT_CFG = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_LIMIT = 2'd0,
		REG_BSIZE = 2'd1,
		REG_TSIZE = 2'd2,
		REG_NONE = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic done;
		logic [DIV_W-1:0] quotient;
		logic [DSR_W-1:0] remainder;
	} div_res_t;

endpackage

@@ sv/task_id_to_buffer_address_core.sv @@
`timescale 1ns / 1ps
// Top level of the task id to buffer address locator.
// Depends on tidba_pkg, tidba_div and tidba_ram.
//
// Usage: requests arrive on in_valid/in_stall with action, start_id, buffer_base,
// buffer_tasks and task_id. Each request gives exactly one result on
// out_valid/out_stall carrying status, task_address, range_start and range_end.
// A window reset or buffer add goes from the execute state to the done state,
// which loads its result into the output register. A lookup runs a radix-2
// division of the id offset by tasks per buffer, then reads the buffer table and
// forms the address in the execute state. The first lookup inside the window
// after reset or after a write to buffer_size or task_size first computes tasks
// per buffer with the same divider. The block takes one request at a time.
// The result sits in an output register, so a new request is accepted while a
// stalled result waits; that request finishes its work and then holds until the
// output register is free. Configuration registers are written through wr_en,
// wr_index and wr_data and must only be written while the block is idle.
// Reset empties the window (start 0, end -1), empties the buffer table and loads
// the register defaults: limit 16, buffer size 4096, task size 64.
module task_id_to_buffer_address_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] action,
	input logic signed [31:0] start_id,
	input logic [31:0] buffer_base,
	input logic [15:0] buffer_tasks,
	input logic signed [31:0] task_id,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] status,
	output logic [31:0] task_address,
	output logic signed [31:0] range_start,
	output logic signed [31:0] range_end,
	input logic wr_en,
	input logic [1:0] wr_index,
	input logic [15:0] wr_data
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_EXEC = 8'b0000_0010,
		S_CHECK = 8'b0000_0100,
		S_PER = 8'b0000_1000,
		S_START = 8'b0001_0000,
		S_DIV = 8'b0010_0000,
		S_IDX = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [tidba_pkg::LIMIT_W-1:0] limit_q;
	logic [tidba_pkg::SIZE_W-1:0] bsize_q;
	logic [tidba_pkg::SIZE_W-1:0] tsize_q;
	logic [tidba_pkg::DSR_W-1:0] per_q;
	logic per_valid_q;

	logic [tidba_pkg::ID_W-1:0] wstart_q;
	logic [tidba_pkg::ID_W-1:0] wend_q;
	logic [tidba_pkg::CNT_W-1:0] used_q;

	tidba_pkg::action_t action_q;
	logic [tidba_pkg::ID_W-1:0] start_q;
	logic [tidba_pkg::ADDR_W-1:0] base_q;
	logic [tidba_pkg::SIZE_W-1:0] tasks_q;
	logic [tidba_pkg::ID_W-1:0] tid_q;
	logic [tidba_pkg::DIV_W-1:0] diff_q;
	logic [tidba_pkg::ADDR_W-1:0] prod_q;
	logic add_pending_q;

	tidba_pkg::status_t stat_q;
	logic [tidba_pkg::ADDR_W-1:0] addr_q;

	logic out_valid_q;
	tidba_pkg::status_t out_status_q;
	logic [tidba_pkg::ADDR_W-1:0] out_addr_q;
	logic [tidba_pkg::ID_W-1:0] out_start_q;
	logic [tidba_pkg::ID_W-1:0] out_end_q;

	logic in_acc;
	logic full;
	logic in_window;
	logic [tidba_pkg::CAP_W-1:0] cap;
	logic ram_we;
	logic [tidba_pkg::ADDR_W-1:0] ram_rdata;
	logic div_start;
	logic [tidba_pkg::DIV_W-1:0] div_dividend;
	logic [tidba_pkg::DSR_W-1:0] div_divisor;
	logic idx_over;
	tidba_pkg::div_res_t div_res;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;

	assign cap = (tidba_pkg::CAP_W'(limit_q) < tidba_pkg::CAP_W'(tidba_pkg::MAX_BUFFERS))
		? tidba_pkg::CAP_W'(limit_q) : tidba_pkg::CAP_W'(tidba_pkg::MAX_BUFFERS);
	assign full = tidba_pkg::CAP_W'(used_q) >= cap;

	assign in_window = !($signed(wstart_q) > $signed(wend_q))
		&& !($signed(tid_q) < $signed(wstart_q))
		&& !($signed(tid_q) > $signed(wend_q));

	assign idx_over = div_res.quotient >= tidba_pkg::DIV_W'(used_q);

	assign ram_we = (state_q == S_EXEC) && (action_q == tidba_pkg::ACT_ADD) && !full;

	assign div_start = ((state_q == S_CHECK) && in_window && (tsize_q != '0) && !per_valid_q)
		|| (state_q == S_START);
	assign div_dividend = (state_q == S_CHECK) ? tidba_pkg::DIV_W'(bsize_q) : diff_q;
	assign div_divisor = (state_q == S_CHECK) ? tsize_q : per_q;

	tidba_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.res(div_res)
	);

	tidba_ram #(
		.WIDTH(tidba_pkg::ADDR_W),
		.DEPTH(tidba_pkg::MAX_BUFFERS)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(used_q[tidba_pkg::IDX_W-1:0]),
		.wdata(base_q),
		.raddr(div_res.quotient[tidba_pkg::IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= tidba_pkg::LIMIT_RESET;
			bsize_q <= tidba_pkg::BSIZE_RESET;
			tsize_q <= tidba_pkg::TSIZE_RESET;
		end else if (wr_en) begin
			unique case (tidba_pkg::reg_index_t'(wr_index))
				tidba_pkg::REG_LIMIT: limit_q <= wr_data[tidba_pkg::LIMIT_W-1:0];
				tidba_pkg::REG_BSIZE: bsize_q <= wr_data;
				tidba_pkg::REG_TSIZE: tsize_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			per_valid_q <= 1'b0;
			wstart_q <= '0;
			wend_q <= '1;
			used_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en && ((tidba_pkg::reg_index_t'(wr_index) == tidba_pkg::REG_BSIZE)
				|| (tidba_pkg::reg_index_t'(wr_index) == tidba_pkg::REG_TSIZE))) begin
				per_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= (tidba_pkg::action_t'(action) == tidba_pkg::ACT_LOOKUP)
							? S_CHECK : S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					if (action_q == tidba_pkg::ACT_RESET) begin
						wstart_q <= start_q;
						wend_q <= start_q - tidba_pkg::ID_W'(1);
						used_q <= '0;
					end else if (ram_we) begin
						used_q <= used_q + tidba_pkg::CNT_W'(1);
						wend_q <= wend_q + tidba_pkg::ID_W'(tasks_q);
					end
				end
				S_CHECK: begin
					priority if (!in_window || (tsize_q == '0)) begin
						state_q <= S_DONE;
					end else if (!per_valid_q) begin
						state_q <= S_PER;
					end else if (per_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_START;
					end
				end
				S_PER: begin
					if (div_res.done) begin
						per_valid_q <= 1'b1;
						state_q <= S_CHECK;
					end
				end
				S_START: state_q <= S_DIV;
				S_DIV: begin
					if (div_res.done) begin
						state_q <= S_IDX;
					end
				end
				S_IDX: state_q <= idx_over ? S_DONE : S_EXEC;
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Lookups reuse the execute state to fold the table read into the address.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					action_q <= tidba_pkg::action_t'(action);
					start_q <= start_id;
					base_q <= buffer_base;
					tasks_q <= buffer_tasks;
					tid_q <= task_id;
					stat_q <= tidba_pkg::STAT_OK;
					addr_q <= '0;
					add_pending_q <= 1'b0;
				end
			end
			S_EXEC: begin
				if (add_pending_q) begin
					addr_q <= ram_rdata + prod_q;
				end else if ((action_q == tidba_pkg::ACT_ADD) && full) begin
					stat_q <= tidba_pkg::STAT_FULL;
				end
			end
			S_CHECK: begin
				diff_q <= tid_q - wstart_q;
				if (!in_window) begin
					stat_q <= tidba_pkg::STAT_MISS;
				end else if ((tsize_q == '0) || (per_valid_q && (per_q == '0))) begin
					stat_q <= tidba_pkg::STAT_CFG;
				end
			end
			S_PER: begin
				if (div_res.done) begin
					per_q <= div_res.quotient[tidba_pkg::DSR_W-1:0];
				end
			end
			S_IDX: begin
				prod_q <= tidba_pkg::ADDR_W'(div_res.remainder) * tidba_pkg::ADDR_W'(tsize_q);
				if (idx_over) begin
					stat_q <= tidba_pkg::STAT_MISS;
				end else begin
					add_pending_q <= 1'b1;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_status_q <= stat_q;
					out_addr_q <= addr_q;
					out_start_q <= wstart_q;
					out_end_q <= wend_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign task_address = out_addr_q;
	assign range_start = out_start_q;
	assign range_end = out_end_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= tidba_pkg::CNT_W'(tidba_pkg::MAX_BUFFERS))
		else $error("buffer count exceeds table depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("result presented without a finished request");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == S_PER || state_q == S_DIV))
		else $error("divider finished outside a division step");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_START) |-> (per_valid_q && per_q != '0))
		else $error("offset division started without a valid divisor");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != tidba_pkg::STAT_OK) |-> (task_address == '0))
		else $error("failed request reports a nonzero address");

endmodule

@@ sv/tidba_ram.sv @@
`timescale 1ns / 1ps
// Generic single write port RAM with one registered read port.
// Stand-alone; depends on nothing.
module tidba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/tidba_div.sv @@
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on tidba_pkg for widths and the result struct.
module tidba_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [tidba_pkg::DIV_W-1:0] dividend,
	input logic [tidba_pkg::DSR_W-1:0] divisor,
	output tidba_pkg::div_res_t res
);

	logic [tidba_pkg::DIV_W-1:0] dvd_q;
	logic [tidba_pkg::DSR_W-1:0] rem_q;
	logic [tidba_pkg::DSR_W-1:0] dsr_q;
	logic [tidba_pkg::DCNT_W-1:0] cnt_q;
	logic done_q;
	logic [tidba_pkg::DSR_W:0] rem_sh;
	logic [tidba_pkg::DSR_W:0] rem_nx;
	logic ge;

	assign rem_sh = {rem_q, dvd_q[tidba_pkg::DIV_W-1]};
	assign ge = rem_sh >= {1'b0, dsr_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == tidba_pkg::DCNT_W'(1));
			if (start) begin
				cnt_q <= tidba_pkg::DCNT_W'(tidba_pkg::DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - tidba_pkg::DCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[tidba_pkg::DIV_W-2:0], ge};
			rem_q <= rem_nx[tidba_pkg::DSR_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quotient = dvd_q;
	assign res.remainder = rem_q;

endmodule
